// File: rtl/cmf_pkg.sv
// Package for the column compare filter: field widths, codes and the
// value compare functions. No dependencies.
package cmf_pkg;

    localparam int MAX_ROWS_DEF = 4096;
    localparam int WORD_BITS    = 64;
    localparam int IDX_W        = 12;
    localparam int CNT_W        = 13;
    localparam int VAL_W        = 64;
    localparam int CMP_W        = 4;
    localparam int IN_DATA_W    = 184;
    localparam int OUT_DATA_W   = 96;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 13;

    // operation codes
    localparam logic [1:0] OP_WR_COL = 2'd0;
    localparam logic [1:0] OP_WR_ORD = 2'd1;
    localparam logic [1:0] OP_SCAN   = 2'd2;
    localparam logic [1:0] OP_RANGE  = 2'd3;

    // compare codes
    localparam logic [3:0] CMP_EQ = 4'd0;
    localparam logic [3:0] CMP_NE = 4'd1;
    localparam logic [3:0] CMP_LT = 4'd2;
    localparam logic [3:0] CMP_LE = 4'd3;
    localparam logic [3:0] CMP_GT = 4'd4;
    localparam logic [3:0] CMP_GE = 4'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_SIZE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIGNED = 8'd1;

    // a < b, signed when sgn is set: the signed compare is done by flipping the sign bits
    function automatic logic val_less(input logic [VAL_W-1:0] a,
                                      input logic [VAL_W-1:0] b,
                                      input logic sgn);
        logic [VAL_W-1:0] aa;
        logic [VAL_W-1:0] bb;
        aa = a ^ {sgn, {(VAL_W-1){1'b0}}};
        bb = b ^ {sgn, {(VAL_W-1){1'b0}}};
        return aa < bb;
    endfunction

    function automatic logic op_match(input logic [CMP_W-1:0] op,
                                      input logic [VAL_W-1:0] a,
                                      input logic [VAL_W-1:0] q,
                                      input logic sgn);
        logic r;
        case (op)
            CMP_EQ:  r = (a == q);
            CMP_NE:  r = (a != q);
            CMP_LT:  r = val_less(a, q, sgn);
            CMP_LE:  r = !val_less(q, a, sgn);
            CMP_GT:  r = val_less(q, a, sgn);
            CMP_GE:  r = !val_less(a, q, sgn);
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/cmf_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module cmf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/column_compare_filter.sv
// Top level of the column compare filter: sequencer, config registers and
// output register around the column and order RAMs. Uses cmf_pkg, cmf_ram.
//
//  channel   dir   handshake            payload
//  s_        in    s_tvalid/s_tready    s_tuser op, s_tdata item fields
//  m_        out   m_tvalid/m_tready    m_tdata result, m_tlast
//  cfg_      in    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A write goes to its RAM while the sequencer stays idle. A scan addresses each examined
// entry, then compares the RAM read data; each match word is then emitted.
// A range search probe addresses the column (through the order table, read first,
// if use_order is set), then compares; up to log2(MAX_ROWS)+1 probes per bound.
// Reset clears control registers, sets signed mode; RAMs hold garbage until written.
// A full output register stalls the sequencer until m_tready takes it.
// MAX_ROWS is a power of two; order entries are reduced by its low bits.
module column_compare_filter
    import cmf_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // operation[1:0]
    input  logic [1:0]            s_tuser,
    // entry_index[11:0] entry_value[75:12] order_entry[87:76] compare_op[91:88]
    // query_value[155:92] query_valid[156] scan_offset[168:157]
    // scan_count[181:169] use_order[182], zero pad [183]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // match_word[63:0] range_begin[76:64] range_end[89:77], zero pad [95:90]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int SW = (CW > CNT_W) ? CW : CNT_W;
    localparam int PW = SW + 1;
    localparam int KW = $clog2(WORD_BITS);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_READ  = 8'b0000_0010,
        ST_EVAL  = 8'b0000_0100,
        ST_EMIT  = 8'b0000_1000,
        ST_RISS  = 8'b0001_0000,
        ST_RORD  = 8'b0010_0000,
        ST_REVAL = 8'b0100_0000,
        ST_RDONE = 8'b1000_0000
    } state_t;

    // input fields
    logic [IDX_W-1:0] in_idx;
    logic [VAL_W-1:0] in_val;
    logic [IDX_W-1:0] in_ord;
    logic [CMP_W-1:0] in_cmp;
    logic [VAL_W-1:0] in_q;
    logic             in_qv;
    logic [IDX_W-1:0] in_off;
    logic [CNT_W-1:0] in_cnt;
    logic             in_useord;

    assign in_idx    = s_tdata[11:0];
    assign in_val    = s_tdata[75:12];
    assign in_ord    = s_tdata[87:76];
    assign in_cmp    = s_tdata[91:88];
    assign in_q      = s_tdata[155:92];
    assign in_qv     = s_tdata[156];
    assign in_off    = s_tdata[168:157];
    assign in_cnt    = s_tdata[181:169];
    assign in_useord = s_tdata[182];

    state_t state_reg, state_next;

    logic [CNT_W-1:0] colsize_reg;
    logic             esigned_reg;

    logic [CMP_W-1:0] cmp_reg, cmp_next;
    logic [VAL_W-1:0] q_reg, q_next;
    logic             usable_reg, usable_next;
    logic             useord_reg, useord_next;
    logic [IDX_W-1:0] off_reg, off_next;
    logic [SW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    rel_reg, rel_next;
    logic [VAL_W-1:0] word_reg, word_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    len_reg, len_next;
    logic             upper_reg, upper_next;
    logic             pass_reg, pass_next;
    logic [CW-1:0]    b_reg, b_next;
    logic [CW-1:0]    e_reg, e_next;

    logic             mval_reg, mval_next;
    logic [VAL_W-1:0] mword_reg, mword_next;
    logic [CNT_W-1:0] mb_reg, mb_next;
    logic [CNT_W-1:0] me_reg, me_next;
    logic             mlast_reg, mlast_next;

    logic             accept;
    logic             out_free;
    logic [SW-1:0]    size_w;
    logic [SW-1:0]    cs_ext;
    logic [SW-1:0]    cnt_sat;
    logic             idx_ok;
    logic [PW-1:0]    pos_w;
    logic             pos_ok;
    logic [CW-1:0]    mid_w;
    logic [CW-1:0]    half_w;
    logic [KW-1:0]    bit_k;
    logic             word_end;
    logic             scan_end;
    logic             go_right;

    logic             col_we;
    logic             ord_we;
    logic [AW-1:0]    col_raddr;
    logic [AW-1:0]    ord_raddr;
    logic [VAL_W-1:0] col_q;
    logic [IDX_W-1:0] ord_q;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !mval_reg || m_tready;

    // column size clipped to the store depth
    assign cs_ext = SW'(colsize_reg);
    assign size_w = (cs_ext > SW'(MAX_ROWS)) ? SW'(MAX_ROWS) : cs_ext;
    assign cnt_sat = (SW'(in_cnt) > SW'(MAX_ROWS)) ? SW'(MAX_ROWS) : SW'(in_cnt);
    assign idx_ok = SW'(in_idx) < SW'(MAX_ROWS);

    // scan position and word bookkeeping
    assign pos_w    = PW'(off_reg) + PW'(rel_reg);
    assign pos_ok   = pos_w < PW'(MAX_ROWS);
    assign bit_k    = rel_reg[KW-1:0];
    assign scan_end = (SW'(rel_reg) + SW'(1)) == cnt_reg;
    assign word_end = (bit_k == {KW{1'b1}}) || scan_end;

    // binary search probe
    assign half_w   = len_reg >> 1;
    assign mid_w    = lo_reg + half_w;
    assign go_right = upper_reg ? !val_less(q_reg, col_q, esigned_reg)
                                : val_less(col_q, q_reg, esigned_reg);

    // RAM ports
    assign col_we = accept && (s_tuser == OP_WR_COL) && idx_ok;
    assign ord_we = accept && (s_tuser == OP_WR_ORD) && idx_ok;

    always_comb begin
        col_raddr = pos_w[AW-1:0];
        ord_raddr = mid_w[AW-1:0];
        case (state_reg)
            ST_RISS: col_raddr = mid_w[AW-1:0];
            ST_RORD: col_raddr = AW'(ord_q);
            default: col_raddr = pos_w[AW-1:0];
        endcase
    end

    cmf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS)) u_col_ram (
        .aclk  (aclk),
        .we    (col_we),
        .waddr (AW'(in_idx)),
        .wdata (in_val),
        .raddr (col_raddr),
        .rdata (col_q)
    );

    cmf_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ROWS)) u_ord_ram (
        .aclk  (aclk),
        .we    (ord_we),
        .waddr (AW'(in_idx)),
        .wdata (in_ord),
        .raddr (ord_raddr),
        .rdata (ord_q)
    );

    // sequencer
    always_comb begin
        state_next  = state_reg;
        cmp_next    = cmp_reg;
        q_next      = q_reg;
        usable_next = usable_reg;
        useord_next = useord_reg;
        off_next    = off_reg;
        cnt_next    = cnt_reg;
        rel_next    = rel_reg;
        word_next   = word_reg;
        lo_next     = lo_reg;
        len_next    = len_reg;
        upper_next  = upper_reg;
        pass_next   = pass_reg;
        b_next      = b_reg;
        e_next      = e_reg;
        mval_next   = mval_reg && !m_tready;
        mword_next  = mword_reg;
        mb_next     = mb_reg;
        me_next     = me_reg;
        mlast_next  = mlast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmp_next    = in_cmp;
                    q_next      = in_q;
                    usable_next = in_qv && (in_cmp <= CMP_GE);
                    useord_next = in_useord;
                    off_next    = in_off;
                    cnt_next    = cnt_sat;
                    rel_next    = '0;
                    word_next   = '0;
                    lo_next     = '0;
                    len_next    = CW'(size_w);
                    b_next      = '0;
                    e_next      = ((in_cmp == CMP_GT) || (in_cmp == CMP_GE))
                                  ? CW'(size_w) : '0;
                    if (s_tuser == OP_SCAN) begin
                        if (cnt_sat != '0) begin
                            state_next = ST_READ;
                        end
                    end else if (s_tuser == OP_RANGE) begin
                        if (!in_qv) begin
                            e_next     = '0;
                            state_next = ST_RDONE;
                        end else if ((in_cmp == CMP_EQ) || (in_cmp == CMP_GT)
                                     || (in_cmp == CMP_GE)) begin
                            pass_next  = 1'b0;
                            upper_next = (in_cmp == CMP_GT);
                            state_next = ST_RISS;
                        end else if ((in_cmp == CMP_LT) || (in_cmp == CMP_LE)) begin
                            pass_next  = 1'b1;
                            upper_next = (in_cmp == CMP_LE);
                            state_next = ST_RISS;
                        end else begin
                            state_next = ST_RDONE;
                        end
                    end
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (usable_reg && pos_ok && op_match(cmp_reg, col_q, q_reg, esigned_reg)) begin
                    word_next = word_reg | (VAL_W'(1) << bit_k);
                end
                if (word_end) begin
                    state_next = ST_EMIT;
                end else begin
                    rel_next   = rel_reg + CW'(1);
                    state_next = ST_READ;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    mval_next  = 1'b1;
                    mword_next = word_reg;
                    mb_next    = '0;
                    me_next    = '0;
                    mlast_next = scan_end;
                    word_next  = '0;
                    if (scan_end) begin
                        state_next = ST_IDLE;
                    end else begin
                        rel_next   = rel_reg + CW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_RISS: begin
                if (len_reg == '0) begin
                    // bound found: finish this pass
                    if (!pass_reg) begin
                        b_next = lo_reg;
                        if (cmp_reg == CMP_EQ) begin
                            pass_next  = 1'b1;
                            upper_next = 1'b1;
                            lo_next    = '0;
                            len_next   = CW'(size_w);
                        end else begin
                            state_next = ST_RDONE;
                        end
                    end else begin
                        e_next     = lo_reg;
                        state_next = ST_RDONE;
                    end
                end else begin
                    state_next = useord_reg ? ST_RORD : ST_REVAL;
                end
            end
            ST_RORD: begin
                state_next = ST_REVAL;
            end
            ST_REVAL: begin
                if (go_right) begin
                    lo_next  = mid_w + CW'(1);
                    len_next = len_reg - half_w - CW'(1);
                end else begin
                    len_next = half_w;
                end
                state_next = ST_RISS;
            end
            ST_RDONE: begin
                if (out_free) begin
                    mval_next  = 1'b1;
                    mword_next = '0;
                    mb_next    = CNT_W'(b_reg);
                    me_next    = CNT_W'(e_reg);
                    mlast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mval_reg    <= 1'b0;
            colsize_reg <= '0;
            esigned_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_COLUMN_SIZE) begin
                    colsize_reg <= cfg_data;
                end else if (cfg_index == REG_ELEMENT_SIGNED) begin
                    esigned_reg <= cfg_data[0];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cmp_reg    <= cmp_next;
        q_reg      <= q_next;
        usable_reg <= usable_next;
        useord_reg <= useord_next;
        off_reg    <= off_next;
        cnt_reg    <= cnt_next;
        rel_reg    <= rel_next;
        word_reg   <= word_next;
        lo_reg     <= lo_next;
        len_reg    <= len_next;
        upper_reg  <= upper_next;
        pass_reg   <= pass_next;
        b_reg      <= b_next;
        e_reg      <= e_next;
        mword_reg  <= mword_next;
        mb_reg     <= mb_next;
        me_reg     <= me_next;
        mlast_reg  <= mlast_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {6'd0, me_reg, mb_reg, mword_reg};

endmodule

// File: rtl/cmf_checker.sv
// Port-level checks for column_compare_filter, bound to the top level.
// Uses cmf_pkg.
module cmf_checker
    import cmf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [1:0]            s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // padding above the range end stays zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:90] == '0))
        else $error("result padding not zero");

    // a scan word carries an empty range
    a_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[63:0] != '0) |-> (m_tdata[89:64] == '0))
        else $error("scan word with range fields set");

    // a write request never brings up a new result
    a_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && ((s_tuser == OP_WR_COL) || (s_tuser == OP_WR_ORD))
        |=> !$rose(m_tvalid))
        else $error("result after write request");

    // a range request closes the input in the cycle after it is accepted
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_RANGE) |=> !s_tready)
        else $error("input open right after range request");

endmodule

bind column_compare_filter cmf_checker u_cmf_checker (.*);
